### rtl/mra_pkg.sv
// mra_pkg: shared types, codes and sizes of the multi-resource allocator
// no dependencies; every other file of the block imports it

package mra_pkg;

  // fixed field sizes of the channels
  localparam int CMD_BITS     = 2;
  localparam int PROC_BITS    = 3;
  localparam int FIELD_BITS   = 8;
  localparam int MAX_TYPES    = 4;
  localparam int OUTCOME_BITS = 3;
  localparam int STATUS_BITS  = 2;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;

  // defaults for the top level parameters
  localparam int DEF_PROCESSES      = 8;
  localparam int DEF_RESOURCE_TYPES = 4;
  localparam int DEF_AMOUNT_BITS    = 8;

  // command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RETRY   = 2'd2
  } cmd_t;

  // process status
  typedef enum logic [STATUS_BITS-1:0] {
    ST_NEW     = 2'd0,
    ST_WAITING = 2'd1,
    ST_RUNNING = 2'd2
  } status_t;

  // result codes
  typedef enum logic [OUTCOME_BITS-1:0] {
    OC_GRANTED       = 3'd0,
    OC_NOW_WAITING   = 3'd1,
    OC_IGNORED       = 3'd2,
    OC_RELEASED      = 3'd3,
    OC_STILL_WAITING = 3'd4,
    OC_SATISFIED     = 3'd5,
    OC_RELEASE_ERROR = 3'd6
  } outcome_t;

  // one input beat as held in the input register
  typedef struct packed {
    logic [CMD_BITS-1:0]                   command;
    logic [PROC_BITS-1:0]                  process;
    logic [MAX_TYPES-1:0][FIELD_BITS-1:0]  amount;
  } item_t;

  // one result beat as held in the result register
  typedef struct packed {
    outcome_t                              outcome;
    status_t                               new_status;
    logic [MAX_TYPES-1:0][FIELD_BITS-1:0]  avail;
  } result_t;

endpackage

### rtl/mra_if.sv
// mra_in_if / mra_out_if: valid/ready channels of the allocator
// depends on mra_pkg for the field widths

interface mra_in_if;
  import mra_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [PROC_BITS-1:0]  process;
  logic [FIELD_BITS-1:0] amount_0;
  logic [FIELD_BITS-1:0] amount_1;
  logic [FIELD_BITS-1:0] amount_2;
  logic [FIELD_BITS-1:0] amount_3;

  modport source (
    output valid, command, process, amount_0, amount_1, amount_2, amount_3,
    input  ready
  );
  modport sink (
    input  valid, command, process, amount_0, amount_1, amount_2, amount_3,
    output ready
  );
endinterface

interface mra_out_if;
  import mra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUTCOME_BITS-1:0] outcome;
  logic [STATUS_BITS-1:0]  new_status;
  logic [FIELD_BITS-1:0]   avail_out_0;
  logic [FIELD_BITS-1:0]   avail_out_1;
  logic [FIELD_BITS-1:0]   avail_out_2;
  logic [FIELD_BITS-1:0]   avail_out_3;

  modport source (
    output valid, outcome, new_status, avail_out_0, avail_out_1, avail_out_2, avail_out_3,
    input  ready
  );
  modport sink (
    input  valid, outcome, new_status, avail_out_0, avail_out_1, avail_out_2, avail_out_3,
    output ready
  );
endinterface

### rtl/mra_in_reg.sv
// mra_in_reg: input register of the allocator, one beat deep
// depends on mra_pkg and mra_in_if

module mra_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  mra_in_if.sink         in_chan,
  input  logic           item_pop,
  output mra_pkg::item_t item,
  output logic           item_valid
);
  import mra_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  // free when empty or when the held beat moves on this cycle
  assign in_chan.ready = !valid_r || item_pop;

  // gather the beat into one word
  always_comb begin
    item_nxt.command   = in_chan.command;
    item_nxt.process   = in_chan.process;
    item_nxt.amount[0] = in_chan.amount_0;
    item_nxt.amount[1] = in_chan.amount_1;
    item_nxt.amount[2] = in_chan.amount_2;
    item_nxt.amount[3] = in_chan.amount_3;
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      valid_r <= 1'b1;
    end else if (item_pop) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;
endmodule

### rtl/mra_core.sv
// mra_core: allocation state, per-beat decision and result register
// depends on mra_pkg and mra_out_if

module mra_core #(
  parameter int PROCESSES      = mra_pkg::DEF_PROCESSES,
  parameter int RESOURCE_TYPES = mra_pkg::DEF_RESOURCE_TYPES,
  parameter int AMOUNT_BITS    = mra_pkg::DEF_AMOUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mra_pkg::item_t                     item,
  input  logic                               item_valid,
  output logic                               item_pop,
  input  logic                               cfg_we,
  input  logic [mra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mra_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  mra_out_if.source                          out_chan
);
  import mra_pkg::*;

  // only indexes the process field can reach get storage
  localparam int PROC_SPAN = 2 ** PROC_BITS;
  localparam int SLOTS     = (PROCESSES < PROC_SPAN) ? PROCESSES : PROC_SPAN;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW        = (AMOUNT_BITS > FIELD_BITS) ? AMOUNT_BITS : FIELD_BITS;

  typedef logic [AMOUNT_BITS-1:0]                     amt_t;
  typedef logic [RESOURCE_TYPES-1:0][AMOUNT_BITS-1:0] vec_t;

  // saturating add at the amount width
  function automatic amt_t sat_add(amt_t a, amt_t b);
    logic [AMOUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AMOUNT_BITS] ? {AMOUNT_BITS{1'b1}} : s[AMOUNT_BITS-1:0];
  endfunction

  // total register value clipped to the amount range
  function automatic amt_t clip_total(logic [CFG_DATA_BITS-1:0] v);
    logic [AW-1:0] e;
    e = AW'(v);
    if (e > AW'({AMOUNT_BITS{1'b1}})) return {AMOUNT_BITS{1'b1}};
    return AMOUNT_BITS'(e);
  endfunction

  // state
  vec_t    held_r [SLOTS];
  vec_t    pend_r [SLOTS];
  status_t stat_r [SLOTS];
  vec_t    avail_r;
  logic    out_valid_r;
  result_t res_r;

  // next values of the addressed entry
  vec_t    held_row_nxt;
  vec_t    pend_row_nxt;
  status_t stat_row_nxt;
  vec_t    avail_nxt;
  result_t res_nxt;

  logic                                 proc_ok;
  logic [SLOT_BITS-1:0]                 slot;
  vec_t                                 cur_held;
  vec_t                                 cur_pend;
  status_t                              cur_stat;
  vec_t                                 amt_v;
  vec_t                                 grant_v;
  logic                                 grant_fits;
  logic                                 release_ok;
  outcome_t                             outcome;
  logic [MAX_TYPES-1:0][FIELD_BITS-1:0] avail_bytes;
  logic                                 fire;

  // a beat moves when the result register is free or being emptied
  assign fire     = item_valid && (!out_valid_r || out_chan.ready);
  assign item_pop = fire;

  // addressed process
  always_comb begin
    proc_ok = (int'(item.process) < SLOTS);
    slot    = proc_ok ? SLOT_BITS'(item.process) : '0;
  end

  assign cur_held = held_r[slot];
  assign cur_pend = pend_r[slot];
  assign cur_stat = stat_r[slot];

  // amounts, grant vector and the per-type compares
  always_comb begin
    grant_fits = 1'b1;
    release_ok = 1'b1;
    for (int t = 0; t < RESOURCE_TYPES; t++) begin
      amt_v[t] = AMOUNT_BITS'(AW'(item.amount[t]));
    end
    grant_v = (cmd_t'(item.command) == CMD_RETRY) ? cur_pend : amt_v;
    for (int t = 0; t < RESOURCE_TYPES; t++) begin
      if (grant_v[t] > avail_r[t]) grant_fits = 1'b0;
      if (amt_v[t] > cur_held[t])  release_ok = 1'b0;
    end
  end

  // command decision
  always_comb begin
    outcome      = OC_IGNORED;
    held_row_nxt = cur_held;
    pend_row_nxt = cur_pend;
    stat_row_nxt = cur_stat;
    avail_nxt    = avail_r;
    if (proc_ok) begin
      case (cmd_t'(item.command))
        CMD_REQUEST: begin
          if (cur_stat != ST_WAITING) begin
            if (grant_fits) begin
              for (int t = 0; t < RESOURCE_TYPES; t++) begin
                held_row_nxt[t] = sat_add(cur_held[t], amt_v[t]);
                avail_nxt[t]    = avail_r[t] - amt_v[t];
              end
              stat_row_nxt = ST_RUNNING;
              outcome      = OC_GRANTED;
            end else begin
              pend_row_nxt = amt_v;
              stat_row_nxt = ST_WAITING;
              outcome      = OC_NOW_WAITING;
            end
          end
        end
        CMD_RELEASE: begin
          if (cur_stat == ST_RUNNING) begin
            if (release_ok) begin
              for (int t = 0; t < RESOURCE_TYPES; t++) begin
                held_row_nxt[t] = cur_held[t] - amt_v[t];
                avail_nxt[t]    = sat_add(avail_r[t], amt_v[t]);
              end
              outcome = OC_RELEASED;
            end else begin
              outcome = OC_RELEASE_ERROR;
            end
          end
        end
        CMD_RETRY: begin
          if (cur_stat == ST_WAITING) begin
            if (grant_fits) begin
              for (int t = 0; t < RESOURCE_TYPES; t++) begin
                held_row_nxt[t] = sat_add(cur_held[t], cur_pend[t]);
                avail_nxt[t]    = avail_r[t] - cur_pend[t];
              end
              pend_row_nxt = '0;
              stat_row_nxt = ST_RUNNING;
              outcome      = OC_SATISFIED;
            end else begin
              outcome = OC_STILL_WAITING;
            end
          end
        end
        default: begin
          outcome = OC_IGNORED;
        end
      endcase
    end
  end

  // available counts as result bytes, absent types read zero
  for (genvar t = 0; t < MAX_TYPES; t++) begin : g_avail
    if (t < RESOURCE_TYPES) begin : g_present
      assign avail_bytes[t] = FIELD_BITS'(AW'(avail_nxt[t]));
    end else begin : g_absent
      assign avail_bytes[t] = '0;
    end
  end

  // result word
  always_comb begin
    res_nxt.outcome    = outcome;
    res_nxt.new_status = proc_ok ? stat_row_nxt : ST_NEW;
    res_nxt.avail      = avail_bytes;
  end

  // allocation state and result valid; a total write reloads its count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < SLOTS; p++) begin
        held_r[p] <= '0;
        pend_r[p] <= '0;
        stat_r[p] <= ST_NEW;
      end
      avail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        if (proc_ok) begin
          held_r[slot] <= held_row_nxt;
          pend_r[slot] <= pend_row_nxt;
          stat_r[slot] <= stat_row_nxt;
        end
        avail_r <= avail_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      for (int t = 0; t < RESOURCE_TYPES; t++) begin
        if (cfg_we && (cfg_index == CFG_IDX_BITS'(t))) begin
          avail_r[t] <= clip_total(cfg_data);
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.outcome     = res_r.outcome;
  assign out_chan.new_status  = res_r.new_status;
  assign out_chan.avail_out_0 = res_r.avail[0];
  assign out_chan.avail_out_1 = res_r.avail[1];
  assign out_chan.avail_out_2 = res_r.avail[2];
  assign out_chan.avail_out_3 = res_r.avail[3];
endmodule

### rtl/multi_resource_allocator_top.sv
// multi_resource_allocator_top: top level of the multi-resource allocator
// depends on mra_pkg, mra_if, mra_in_reg and mra_core
//
// Usage
//   in_chan carries one command beat (request, release, retry) for one
//   process with one amount per resource type. out_chan returns exactly
//   one result beat per command: outcome, the process status afterwards
//   and the available count of every resource type afterwards.
//   cfg_we/cfg_index/cfg_data write the total of one resource type; the
//   write reloads that type's available count and touches nothing else.
//   Write totals only while no command is in flight.
// Path and throughput
//   A beat taken from in_chan sits in the input register, and its result
//   is registered in the result register, which drives out_chan.valid.
//   The whole decision is one pass of compares and add/subtract on the
//   state registers: one command per cycle while out_chan.ready is high.
// Reset
//   rst_n low (synchronous) clears held and pending amounts, sets every
//   process to new and every available count to zero, and empties both
//   registers. Totals have to be written after reset.
// Stalls
//   While out_chan.ready is low the result is held, the input register
//   keeps one more beat, and in_chan.ready drops until the result goes.

module multi_resource_allocator_top #(
  parameter int PROCESSES      = mra_pkg::DEF_PROCESSES,
  parameter int RESOURCE_TYPES = mra_pkg::DEF_RESOURCE_TYPES,
  parameter int AMOUNT_BITS    = mra_pkg::DEF_AMOUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mra_in_if.sink                             in_chan,
  mra_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [mra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mra_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mra_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // input register
  mra_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item_pop   (item_pop),
    .item       (item),
    .item_valid (item_valid)
  );

  // state, decision and result register
  mra_core #(
    .PROCESSES      (PROCESSES),
    .RESOURCE_TYPES (RESOURCE_TYPES),
    .AMOUNT_BITS    (AMOUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_chan   (out_chan)
  );

  // a granted beat always leaves its process running
  a_grant_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.outcome == OC_GRANTED || out_chan.outcome == OC_SATISFIED)
      |-> out_chan.new_status == ST_RUNNING)
    else $error("grant without running status");

  // a beat that leaves the request pending reports a waiting process
  a_wait_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.outcome == OC_NOW_WAITING ||
                       out_chan.outcome == OC_STILL_WAITING)
      |-> out_chan.new_status == ST_WAITING)
    else $error("pending request without waiting status");

  // both registers full and the result stalled: no new beat may enter
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_chan.valid && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while pipeline is full");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !item_pop)
    else $error("result register overwritten under stall");
endmodule
